/* rtl/core/pli_pkg.sv */
// ---------------------------------------------------------------------------
// pli_pkg
// Shared codes and constants of the piecewise linear interpolation unit.
// ---------------------------------------------------------------------------
package pli_pkg;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SEG     = 2'd1,
        ST_ZERO_WIDTH = 2'd2,
        ST_SAT        = 2'd3
    } status_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int CFG_INDEX_WIDTH   = 1;
    localparam int CFG_DATA_WIDTH    = 16;
    localparam int COUNT_WIDTH       = 7;
    localparam int MARGIN_WIDTH      = 16;
    localparam int POINT_INDEX_WIDTH = 6;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POINT_COUNT  = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLAMP_MARGIN = 1'b1;

    localparam logic [COUNT_WIDTH-1:0]  COUNT_RESET  = 7'd2;
    localparam logic [MARGIN_WIDTH-1:0] MARGIN_RESET = 16'd7;

endpackage

/* rtl/core/pli_if.sv */
// ---------------------------------------------------------------------------
// pli_req_if / pli_rsp_if
// Valid/ready channels carrying request and response items.
// ---------------------------------------------------------------------------
interface pli_req_if #(
    parameter int VALUE_WIDTH = 32
);
    import pli_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [POINT_INDEX_WIDTH-1:0]  point_index;
    logic signed [VALUE_WIDTH-1:0] x_value;
    logic signed [VALUE_WIDTH-1:0] y_value;

    modport source (output valid, output op, output point_index, output x_value,
                    output y_value, input ready);
    modport sink   (input valid, input op, input point_index, input x_value,
                    input y_value, output ready);
endinterface

interface pli_rsp_if #(
    parameter int VALUE_WIDTH = 32
);
    import pli_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] interp_y;
    status_t                       status;

    modport source (output valid, output interp_y, output status, input ready);
    modport sink   (input valid, input interp_y, input status, output ready);
endinterface

/* rtl/core/piecewise_linear_interp_unit.sv */
// ---------------------------------------------------------------------------
// piecewise_linear_interp_unit
// Breakpoint table with clamped, saturating linear interpolation.
//
//   Channel  Dir  Handshake     Payload
//   req      in   valid/ready   op, point_index, x_value, y_value
//   rsp      out  valid/ready   interp_y, status
//   cfg      in   cfg_we        cfg_index, cfg_wdata
//
// A write item passes the front register and the queue before it reaches the table.
// A query scans for its segment with one table read per cycle, then runs
// VALUE_WIDTH+1 multiply steps and 2*VALUE_WIDTH+3 divide steps.
// Reset is asynchronous; the tables are not cleared. A stalled response
// holds the back end; the front end keeps accepting until three items wait.
// ---------------------------------------------------------------------------
module piecewise_linear_interp_unit #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pli_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [pli_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    pli_req_if.sink                             req,
    pli_rsp_if.source                           rsp
);
    import pli_pkg::*;

    localparam int EW = 2 + 2*$clog2(TABLE_DEPTH) + 2*VALUE_WIDTH;

    logic [COUNT_WIDTH-1:0]  point_count_reg;
    logic [MARGIN_WIDTH-1:0] clamp_margin_reg;
    logic                    f_valid;
    logic                    f_ready;
    logic [EW-1:0]           f_data;
    logic                    b_valid;
    logic                    b_ready;
    logic [EW-1:0]           b_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg  <= COUNT_RESET;
            clamp_margin_reg <= MARGIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POINT_COUNT:  point_count_reg  <= cfg_wdata[COUNT_WIDTH-1:0];
                CFG_CLAMP_MARGIN: clamp_margin_reg <= cfg_wdata[MARGIN_WIDTH-1:0];
                default:          point_count_reg  <= point_count_reg;
            endcase
        end
    end

    pli_front #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .point_count (point_count_reg),
        .push_valid  (f_valid),
        .push_ready  (f_ready),
        .push_data   (f_data)
    );

    pli_queue #(.WIDTH(EW), .DEPTH(2)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    pli_back #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (b_valid),
        .pop_ready    (b_ready),
        .pop_data     (b_data),
        .clamp_margin (clamp_margin_reg),
        .rsp          (rsp)
    );
endmodule

/* rtl/core/pli_ram.sv */
// ---------------------------------------------------------------------------
// pli_ram
// Simple dual-port RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/core/pli_queue.sv */
// ---------------------------------------------------------------------------
// pli_queue
// Small FIFO that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module pli_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != (PW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

/* rtl/core/pli_front.sv */
// ---------------------------------------------------------------------------
// pli_front
// Accepts request items, decodes them and hands them to the queue.
// ---------------------------------------------------------------------------
module pli_front #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    pli_req_if.sink                          req,
    input  logic [pli_pkg::COUNT_WIDTH-1:0]  point_count,
    output logic                             push_valid,
    input  logic                             push_ready,
    output logic [1+1+2*$clog2(TABLE_DEPTH)+2*VALUE_WIDTH-1:0] push_data
);
    import pli_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    typedef struct packed {
        logic                          is_query;
        logic                          wr_ok;
        logic [AW-1:0]                 addr;
        logic [AW-1:0]                 last;
        logic signed [VALUE_WIDTH-1:0] x;
        logic signed [VALUE_WIDTH-1:0] y;
    } entry_t;

    entry_t     entry;
    entry_t     data_reg;
    logic       full_reg;
    logic [AW:0] n_eff;

    always_comb
    begin
        if (point_count < COUNT_WIDTH'(2))
        begin
            n_eff = (AW+1)'(2);
        end
        else if (int'(point_count) > TABLE_DEPTH)
        begin
            n_eff = (AW+1)'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = (AW+1)'(point_count);
        end
        entry.is_query = (req.op == OP_QUERY);
        entry.wr_ok    = (int'(req.point_index) < TABLE_DEPTH);
        entry.addr     = AW'(req.point_index);
        entry.last     = AW'(n_eff - 1'b1);
        entry.x        = req.x_value;
        entry.y        = req.y_value;
    end

    assign req.ready  = !full_reg || push_ready;
    assign push_valid = full_reg;
    assign push_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            full_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            data_reg <= entry;
        end
    end
endmodule

/* rtl/core/pli_back.sv */
// ---------------------------------------------------------------------------
// pli_back
// Holds the breakpoint tables, scans for the bracketing segment and
// interpolates with a shift-add multiplier and a restoring divider.
// ---------------------------------------------------------------------------
module pli_back #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  logic [1+1+2*$clog2(TABLE_DEPTH)+2*VALUE_WIDTH-1:0] pop_data,
    input  logic [pli_pkg::MARGIN_WIDTH-1:0]  clamp_margin,
    pli_rsp_if.source                         rsp
);
    import pli_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int VW = VALUE_WIDTH;
    localparam int XW = VW + 1;
    localparam int DW = VW + 2;
    localparam int PW = DW + XW;
    localparam int CW = $clog2(PW + 1);

    localparam logic signed [DW-1:0] SUM_MAX = {3'b000, {(VW-1){1'b1}}};
    localparam logic signed [DW-1:0] SUM_MIN = {3'b111, {(VW-1){1'b0}}};

    typedef struct packed {
        logic                 is_query;
        logic                 wr_ok;
        logic [AW-1:0]        addr;
        logic [AW-1:0]        last;
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE, S_WAIT0, S_FIRST, S_LAST, S_SCAN0, S_SCAN,
        S_YWAIT, S_Y0, S_Y1, S_MUL, S_DIV, S_SUM, S_OUT
    } state_t;

    entry_t               entry;
    state_t               state_reg;
    logic [AW-1:0]        rd_addr_reg;
    logic [AW-1:0]        k_reg;
    logic [AW-1:0]        last_reg;
    logic signed [VW-1:0] xq_reg;
    logic signed [VW-1:0] xf_reg;
    logic signed [XW-1:0] x0_reg;
    logic signed [VW-1:0] prev_reg;
    logic signed [VW-1:0] xj_reg;
    logic signed [VW-1:0] xj1_reg;
    logic signed [VW-1:0] yj_reg;
    logic [PW-1:0]        mcand_reg;
    logic [XW-1:0]        mplier_reg;
    logic [PW-1:0]        prod_reg;
    logic [XW-1:0]        c_reg;
    logic [XW-1:0]        rem_reg;
    logic                 neg_reg;
    logic [CW-1:0]        cnt_reg;
    logic signed [VW-1:0] res_y_reg;
    status_t              res_st_reg;
    logic                 out_valid_reg;
    logic signed [VW-1:0] out_y_reg;
    status_t              out_st_reg;

    logic                 ram_we;
    logic [VW-1:0]        x_rd_raw;
    logic [VW-1:0]        y_rd_raw;
    logic signed [VW-1:0] x_rd;
    logic signed [VW-1:0] y_rd;
    logic signed [XW-1:0] margin_ext;
    logic signed [XW-1:0] x0_clamp;
    logic signed [XW-1:0] prev_ext;
    logic signed [XW-1:0] cur_ext;
    logic                 bracket;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [DW-1:0] d;
    logic [XW-1:0]        dx_mag;
    logic [XW-1:0]        dy_mag;
    logic [DW-1:0]        d_mag;
    logic                 neg_calc;
    logic [XW:0]          rem_s;
    logic [XW:0]          rem_diff;
    logic                 rem_ge;
    logic [XW-1:0]        q;
    logic signed [DW-1:0] q_signed;
    logic signed [DW-1:0] sum;
    logic                 out_free;
    logic                 out_load;

    assign entry     = pop_data;
    assign pop_ready = (state_reg == S_IDLE);
    assign ram_we    = pop_valid && pop_ready && !entry.is_query && entry.wr_ok;

    pli_ram #(.WIDTH(VW), .DEPTH(TABLE_DEPTH)) u_x_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (entry.addr),
        .wdata (entry.x),
        .raddr (rd_addr_reg),
        .rdata (x_rd_raw)
    );

    pli_ram #(.WIDTH(VW), .DEPTH(TABLE_DEPTH)) u_y_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (entry.addr),
        .wdata (entry.y),
        .raddr (rd_addr_reg),
        .rdata (y_rd_raw)
    );

    assign x_rd = $signed(x_rd_raw);
    assign y_rd = $signed(y_rd_raw);

    always_comb
    begin
        margin_ext = $signed({{(XW-MARGIN_WIDTH){1'b0}}, clamp_margin});
        if (xq_reg < xf_reg)
        begin
            x0_clamp = XW'(xf_reg) + margin_ext;
        end
        else if (xq_reg > x_rd)
        begin
            x0_clamp = XW'(x_rd) - margin_ext;
        end
        else
        begin
            x0_clamp = XW'(xq_reg);
        end

        prev_ext = XW'(prev_reg);
        cur_ext  = XW'(x_rd);
        bracket  = ((x0_reg <= prev_ext) && (x0_reg >= cur_ext)) ||
                   ((x0_reg >= prev_ext) && (x0_reg <= cur_ext));

        dx     = XW'(xj1_reg) - XW'(xj_reg);
        dy     = XW'(y_rd) - XW'(yj_reg);
        d      = DW'(x0_reg) - DW'(xj_reg);
        dx_mag = dx[XW-1] ? XW'(-dx) : XW'(dx);
        dy_mag = dy[XW-1] ? XW'(-dy) : XW'(dy);
        d_mag  = d[DW-1] ? DW'(-d) : DW'(d);
        neg_calc = ((d[DW-1] != dy[XW-1]) != dx[XW-1]) && (d != '0) && (dy != '0);

        rem_s    = {rem_reg, prod_reg[PW-1]};
        rem_ge   = (rem_s >= {1'b0, c_reg});
        rem_diff = rem_s - {1'b0, c_reg};

        q        = prod_reg[XW-1:0];
        q_signed = neg_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        sum      = DW'(yj_reg) + q_signed;

        out_free = !out_valid_reg || rsp.ready;
        out_load = (state_reg == S_OUT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rd_addr_reg   <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop_valid && entry.is_query)
                    begin
                        xq_reg      <= entry.x;
                        last_reg    <= entry.last;
                        rd_addr_reg <= '0;
                        state_reg   <= S_WAIT0;
                    end
                end
                S_WAIT0:
                begin
                    rd_addr_reg <= last_reg;
                    state_reg   <= S_FIRST;
                end
                S_FIRST:
                begin
                    xf_reg      <= x_rd;
                    rd_addr_reg <= '0;
                    state_reg   <= S_LAST;
                end
                S_LAST:
                begin
                    x0_reg      <= x0_clamp;
                    rd_addr_reg <= AW'(1);
                    k_reg       <= AW'(1);
                    state_reg   <= S_SCAN0;
                end
                S_SCAN0:
                begin
                    prev_reg    <= x_rd;
                    rd_addr_reg <= k_reg + 1'b1;
                    state_reg   <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (bracket)
                    begin
                        xj_reg      <= prev_reg;
                        xj1_reg     <= x_rd;
                        rd_addr_reg <= k_reg - 1'b1;
                        state_reg   <= S_YWAIT;
                    end
                    else if (k_reg == last_reg)
                    begin
                        res_y_reg  <= '0;
                        res_st_reg <= ST_NO_SEG;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        prev_reg    <= x_rd;
                        k_reg       <= k_reg + 1'b1;
                        rd_addr_reg <= k_reg + AW'(2);
                    end
                end
                S_YWAIT:
                begin
                    rd_addr_reg <= k_reg;
                    state_reg   <= S_Y0;
                end
                S_Y0:
                begin
                    yj_reg    <= y_rd;
                    state_reg <= S_Y1;
                end
                S_Y1:
                begin
                    if (dx == '0)
                    begin
                        res_y_reg  <= '0;
                        res_st_reg <= ST_ZERO_WIDTH;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        mcand_reg  <= PW'(d_mag);
                        mplier_reg <= dy_mag;
                        prod_reg   <= '0;
                        c_reg      <= dx_mag;
                        neg_reg    <= neg_calc;
                        cnt_reg    <= '0;
                        state_reg  <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (mplier_reg[0])
                    begin
                        prod_reg <= prod_reg + mcand_reg;
                    end
                    mcand_reg  <= {mcand_reg[PW-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[XW-1:1]};
                    if (cnt_reg == CW'(XW-1))
                    begin
                        cnt_reg   <= '0;
                        rem_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DIV:
                begin
                    rem_reg  <= rem_ge ? rem_diff[XW-1:0] : rem_s[XW-1:0];
                    prod_reg <= {prod_reg[PW-2:0], rem_ge};
                    if (cnt_reg == CW'(PW-1))
                    begin
                        state_reg <= S_SUM;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_SUM:
                begin
                    if (sum > SUM_MAX)
                    begin
                        res_y_reg  <= SUM_MAX[VW-1:0];
                        res_st_reg <= ST_SAT;
                    end
                    else if (sum < SUM_MIN)
                    begin
                        res_y_reg  <= SUM_MIN[VW-1:0];
                        res_st_reg <= ST_SAT;
                    end
                    else
                    begin
                        res_y_reg  <= sum[VW-1:0];
                        res_st_reg <= ST_OK;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_y_reg  <= res_y_reg;
                        out_st_reg <= res_st_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.interp_y = out_y_reg;
    assign rsp.status   = out_st_reg;
endmodule

/* rtl/core/pli_checker.sv */
// ---------------------------------------------------------------------------
// pli_checker
// Checks on the response port of the interpolation unit.
// ---------------------------------------------------------------------------
module pli_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic signed [VALUE_WIDTH-1:0] interp_y,
    input logic [1:0]                    status
);
    import pli_pkg::*;

    localparam logic [VALUE_WIDTH-1:0] Y_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] Y_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(interp_y) && $stable(status))
        else $error("response changed while stalled");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_NO_SEG || status == ST_ZERO_WIDTH) |-> interp_y == '0)
        else $error("fault response carries a non-zero value");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_SAT |-> interp_y == Y_MAX || interp_y == Y_MIN)
        else $error("saturated response is not at a bound");
endmodule

bind piecewise_linear_interp_unit pli_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_pli_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .interp_y  (rsp.interp_y),
    .status    (rsp.status)
);
